### rtl/baro_sensor_compensation_assert.svh
// Assertion macros shared by the barometric compensation RTL.
`ifndef BARO_SENSOR_COMPENSATION_ASSERT_SVH
`define BARO_SENSOR_COMPENSATION_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define BSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define BSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// Barometric compensation package
// Register indexes, sizes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none
package bsc_pkg;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned DivW = 32;
	localparam logic [CfgIdxW-1:0] REG_AC1_AC2 = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_AC3_AC4 = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_AC5_AC6 = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_B1_B2 = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_MC_MD = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_OSS = 3'd5;

	// Divider request side-band.
	typedef struct packed {
		logic valid;
		logic err;
	} div_ctl_t;
endpackage
`default_nettype wire

### rtl/baro_sensor_compensation.sv
// ----------------------------------------------------------------------------
// Barometric sensor compensation
// Integer temperature and pressure compensation from calibration registers.
// ----------------------------------------------------------------------------
// channel   direction  content
// s_axis    in         raw_temperature, raw_pressure
// m_axis    out        temperature_decidegree, pressure_pascal, divide_error
// cfg       in         write enable, index, data
// One request enters per cycle while the output is not stalled; its result
// passes through nine stage registers, the two 32-stage divider pipelines
// and the output register.
// The whole pipeline advances together; an output register is refilled when
// it empties or is being taken, so a stall holds every stage in place.
// Reset clears the valid bits and the coefficient registers.
`default_nettype none
module baro_sensor_compensation (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [bsc_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// [15:0] raw_temperature, [34:16] raw_pressure, zero filled
	input  wire logic [39:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	// [27:0] temperature_decidegree, [59:28] pressure_pascal, [60] divide_error
	output logic [63:0] m_axis_tdata
);
	import bsc_pkg::*;
	`include "baro_sensor_compensation_assert.svh"

	logic [31:0] c12_q, c34_q, c56_q, cb_q, cm_q;
	logic [1:0] oss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c12_q <= '0; c34_q <= '0; c56_q <= '0; cb_q <= '0; cm_q <= '0;
			oss_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AC1_AC2: c12_q <= cfg_data;
				REG_AC3_AC4: c34_q <= cfg_data;
				REG_AC5_AC6: c56_q <= cfg_data;
				REG_B1_B2: cb_q <= cfg_data;
				REG_MC_MD: cm_q <= cfg_data;
				REG_OSS: oss_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic [31:0] ac4, ac5, ac6;
	assign ac1 = {{16{c12_q[31]}}, c12_q[31:16]};
	assign ac2 = {{16{c12_q[15]}}, c12_q[15:0]};
	assign ac3 = {{16{c34_q[31]}}, c34_q[31:16]};
	assign ac4 = {16'd0, c34_q[15:0]};
	assign ac5 = {16'd0, c56_q[31:16]};
	assign ac6 = {16'd0, c56_q[15:0]};
	assign b1 = {{16{cb_q[31]}}, cb_q[31:16]};
	assign b2 = {{16{cb_q[15]}}, cb_q[15:0]};
	assign mc = {{16{cm_q[31]}}, cm_q[31:16]};
	assign md = {{16{cm_q[15]}}, cm_q[15:0]};

	logic en;
	logic out_v_q;
	assign en = !out_v_q || m_axis_tready;
	assign s_axis_tready = en;
	logic acc;
	assign acc = s_axis_tvalid && s_axis_tready;

	// Stage 1: x1 product.
	logic v_s1; logic [31:0] prod_s1; logic [18:0] up_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= acc;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= ({16'd0, s_axis_tdata[15:0]} - ac6) * ac5;
			up_s1 <= s_axis_tdata[34:16];
		end
	end

	// Stage 2: x1 and temperature divisor, signs resolved.
	logic v_s2; logic [31:0] x1_s2, tn_s2, td_s2; logic tneg_s2; logic [18:0] up_s2;
	logic signed [31:0] x1c, dsum, tnum;
	always_comb begin
		x1c = $signed(prod_s1) >>> 15;
		dsum = x1c + md;
		tnum = mc <<< 11;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x1_s2 <= x1c;
			tn_s2 <= tnum[31] ? -tnum : tnum;
			td_s2 <= dsum[31] ? -dsum : dsum;
			tneg_s2 <= tnum[31] ^ dsum[31];
			up_s2 <= up_s1;
		end
	end

	logic tdv_v; logic [31:0] tq; logic tz; logic [127:0] tside;
	bsc_div u_tdiv (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2),
		.num(tn_s2), .den(td_s2),
		.side_in({76'd0, tneg_s2, up_s2, x1_s2}),
		.out_valid(tdv_v), .quo(tq), .zero_den(tz), .side_out(tside)
	);

	// Stage 3: b5, temperature, b6.
	logic v_s3; logic [31:0] b6_s3, temp_s3; logic terr_s3; logic [18:0] up_s3;
	logic [31:0] b5c;
	assign b5c = tside[31:0] + (tside[51] ? -tq : tq);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= tdv_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			b6_s3 <= b5c - 32'd4000;
			temp_s3 <= $signed(b5c + 32'd8) >>> 4;
			terr_s3 <= tz;
			up_s3 <= tside[50:32];
		end
	end

	// Stage 4: b6 square, ac2*b6, ac3*b6.
	logic v_s4; logic [31:0] sqp_s4, a2_s4, a3_s4, temp_s4; logic terr_s4;
	logic [18:0] up_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sqp_s4 <= b6_s3 * b6_s3;
			a2_s4 <= ac2 * b6_s3;
			a3_s4 <= ac3 * b6_s3;
			temp_s4 <= temp_s3; terr_s4 <= terr_s3; up_s4 <= up_s3;
		end
	end

	// Stage 5: b2*sq, b1*sq.
	logic v_s5; logic [31:0] b2p_s5, b1p_s5, a2_s5, a3_s5, temp_s5; logic terr_s5;
	logic [18:0] up_s5; logic signed [31:0] sq;
	assign sq = $signed(sqp_s4) >>> 12;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			b2p_s5 <= b2 * sq;
			b1p_s5 <= b1 * sq;
			a2_s5 <= $signed(a2_s4) >>> 11;
			a3_s5 <= $signed(a3_s4) >>> 13;
			temp_s5 <= temp_s4; terr_s5 <= terr_s4; up_s5 <= up_s4;
		end
	end

	// Stage 6: b3 and x3 for b4.
	logic v_s6; logic [31:0] b3_s6, x3_s6, temp_s6; logic terr_s6; logic [18:0] up_s6;
	logic [31:0] x3a, bsh, b3c, x3b;
	always_comb begin
		// Each arithmetic shift is sized on its own so the sum around it
		// cannot turn it into a logical shift.
		x3a = $unsigned($signed(b2p_s5) >>> 11) + a2_s5;
		bsh = ((ac1 <<< 2) + x3a) << oss_q;
		bsh = bsh + 32'd2;
		// Truncating divide by four.
		b3c = $signed(bsh[31] ? bsh + 32'd3 : bsh) >>> 2;
		x3b = $signed(a3_s5 + $unsigned($signed(b1p_s5) >>> 16) + 32'd2) >>> 2;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			b3_s6 <= b3c; x3_s6 <= x3b + 32'd32768;
			temp_s6 <= temp_s5; terr_s6 <= terr_s5; up_s6 <= up_s5;
		end
	end

	// Stage 7: b4 and b7 products.
	logic v_s7; logic [31:0] b4_s7, b7_s7, temp_s7; logic terr_s7;
	logic [31:0] b4p, b7p;
	always_comb begin
		b4p = ac4 * x3_s6;
		b7p = ({13'd0, up_s6} - b3_s6) * (32'd50000 >> oss_q);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			b4_s7 <= b4p >> 15; b7_s7 <= b7p;
			temp_s7 <= temp_s6; terr_s7 <= terr_s6;
		end
	end

	logic pdv_v; logic [31:0] pq; logic pz; logic [127:0] pside;
	logic [31:0] pnum;
	assign pnum = b7_s7[31] ? b7_s7 : (b7_s7 << 1);
	bsc_div u_pdiv (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s7),
		.num(pnum), .den(b4_s7),
		.side_in({98'd0, b7_s7[31], terr_s7, temp_s7[27:0]}),
		.out_valid(pdv_v), .quo(pq), .zero_den(pz), .side_out(pside)
	);

	// Stage 8: p and its square term.
	logic v_s8; logic [31:0] p_s8, x1p_s8, x2p_s8; logic [27:0] temp_s8; logic err_s8;
	logic [31:0] pc, p8;
	always_comb begin
		pc = pside[29] ? (pq << 1) : pq;
		p8 = $signed(pc) >>> 8;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (en) v_s8 <= pdv_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p_s8 <= pc;
			x1p_s8 <= p8 * p8;
			x2p_s8 <= pc * 32'hFFFF_E343;
			temp_s8 <= pside[27:0];
			err_s8 <= pside[28] | pz;
		end
	end

	// Stage 9: 3038 scaling.
	logic v_s9; logic [31:0] p_s9, x1m_s9, x2_s9; logic [27:0] temp_s9; logic err_s9;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (en) v_s9 <= v_s8;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			x1m_s9 <= x1p_s8 * 32'd3038;
			x2_s9 <= $signed(x2p_s8) >>> 16;
			p_s9 <= p_s8; temp_s9 <= temp_s8; err_s9 <= err_s8;
		end
	end

	// Output register.
	logic [31:0] pf, corr;
	always_comb begin
		corr = $unsigned($signed(x1m_s9) >>> 16) + x2_s9 + 32'd3791;
		pf = p_s9 + $unsigned($signed(corr) >>> 4);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= v_s9;
	end
	always_ff @(posedge clk) begin
		if (en) m_axis_tdata <= {3'd0, err_s9, pf, temp_s9};
	end
	assign m_axis_tvalid = out_v_q;

	`BSC_ASSERT_NEXT(a_stall, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))
	`BSC_ASSERT_IMPL(a_ready, clk, arst_n, !m_axis_tvalid, s_axis_tready)
	`BSC_ASSERT_NEXT(a_flow, clk, arst_n, en && v_s9, m_axis_tvalid)
endmodule
`default_nettype wire

### rtl/bsc_div.sv
// ----------------------------------------------------------------------------
// Pipelined divider
// Unsigned restoring division, one quotient bit per stage, with a payload
// that travels along. Zero divisor gives zero quotient and flags it.
// ----------------------------------------------------------------------------
`default_nettype none
module bsc_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic [31:0] num,
	input  wire logic [31:0] den,
	input  wire logic [127:0] side_in,
	output logic out_valid,
	output logic [31:0] quo,
	output logic zero_den,
	output logic [127:0] side_out
);
	import bsc_pkg::*;
	`include "baro_sensor_compensation_assert.svh"

	logic vld_q [1:DivW];
	logic [31:0] rem_q [1:DivW];
	logic [31:0] qt_q [1:DivW];
	logic [31:0] dv_q [1:DivW];
	logic [127:0] sd_q [1:DivW];

	for (genvar i = 0; i < DivW; i++) begin : g_st
		logic v_in;
		logic [31:0] rem_in, qt_in, dv_in;
		logic [127:0] sd_in;
		logic [32:0] trial;
		logic [32:0] sh;
		// The first stage takes the request straight from the ports.
		if (i == 0) begin : g_first
			assign v_in = in_valid;
			assign rem_in = 32'd0;
			assign qt_in = num;
			assign dv_in = den;
			assign sd_in = side_in;
		end else begin : g_next
			assign v_in = vld_q[i];
			assign rem_in = rem_q[i];
			assign qt_in = qt_q[i];
			assign dv_in = dv_q[i];
			assign sd_in = sd_q[i];
		end
		assign sh = {rem_in, qt_in[31]};
		assign trial = sh - {1'b0, dv_in};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i+1] <= 1'b0;
			end else if (en) begin
				vld_q[i+1] <= v_in;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!trial[32]) begin
					rem_q[i+1] <= trial[31:0];
					qt_q[i+1] <= {qt_in[30:0], 1'b1};
				end else begin
					rem_q[i+1] <= sh[31:0];
					qt_q[i+1] <= {qt_in[30:0], 1'b0};
				end
				dv_q[i+1] <= dv_in;
				sd_q[i+1] <= sd_in;
			end
		end
	end

	assign out_valid = vld_q[DivW];
	assign zero_den = (dv_q[DivW] == 32'd0);
	assign quo = zero_den ? 32'd0 : qt_q[DivW];
	assign side_out = sd_q[DivW];

	`BSC_ASSERT_NEXT(a_hold, clk, arst_n, !en, vld_q[DivW] == $past(vld_q[DivW]))
	`BSC_ASSERT_NEXT(a_move, clk, arst_n, en && vld_q[DivW-1], vld_q[DivW])
	`BSC_ASSERT_IMPL(a_zero, clk, arst_n, out_valid && zero_den, quo == 32'd0)
endmodule
`default_nettype wire
